FILE: rtl/core/bzs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzs_pkg
// shared constants, command codes and the in-word encoder of the bitmap search
// ----------------------------------------------------------------------------
package bzs_pkg;

   localparam int WORD_BITS     = 32;
   localparam int ANS_W         = 14;
   localparam int IDX_W         = 8;
   localparam int GRP_WORDS     = 16;
   localparam int DEFAULT_WORDS = 256;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = 16;
   localparam int CSR_TDATA_W   = 16;

   localparam logic [ANS_W-1:0] RESET_SIZE = 14'd8192;

   typedef enum logic [1:0] {
      CMD_WRITE      = 2'd0,
      CMD_FIND_FIRST = 2'd1,
      CMD_FIND_NEXT  = 2'd2,
      CMD_COUNT      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic       found;
      logic [4:0] offset;
   } hit_type;

   // first set bit counted from the msb (offset 0 is bit 31)
   function automatic hit_type first_one_msb(input logic [WORD_BITS-1:0] v);
      hit_type h;
      h.found  = |v;
      h.offset = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) begin
            h.offset = 5'(WORD_BITS - 1 - i);
         end
      end
      return h;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bzs_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzs_store
// bitmap word memory with per-word full and empty summary flags
// ----------------------------------------------------------------------------
module bzs_store
   import bzs_pkg::*;
#(
   parameter int WORDS = DEFAULT_WORDS,
   parameter int IW    = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [IW-1:0]        wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [IW-1:0]        rd_addr,
   output logic      [WORD_BITS-1:0] rd_data,
   output logic      [WORDS-1:0]     nonfull,
   output logic      [WORDS-1:0]     nonempty
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] mem_q_ff;
   logic                 empty_q_ff;
   logic [WORDS-1:0]     full_ff;
   logic [WORDS-1:0]     empty_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         empty_q_ff <= empty_ff[rd_addr];
      end
   end

   // empty flag doubles as the valid bit: a never-written word reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= '0;
         empty_ff <= '1;
      end else if (wr_en) begin
         full_ff[wr_addr]  <= &wr_data;
         empty_ff[wr_addr] <= ~|wr_data;
      end
   end

   assign rd_data  = empty_q_ff ? '0 : mem_q_ff;
   assign nonfull  = ~full_ff;
   assign nonempty = ~empty_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bzs_locate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzs_locate
// finds the first flagged word after a base word, two-level priority encode
// ----------------------------------------------------------------------------
module bzs_locate
   import bzs_pkg::*;
#(
   parameter int WORDS = DEFAULT_WORDS,
   parameter int IW    = 8
) (
   input  wire logic             clock,
   input  wire logic             strobe,
   input  wire logic [WORDS-1:0] flags,
   input  wire logic [IW-1:0]    base,
   output logic                  found,
   output logic      [IW-1:0]    word
);

   localparam int NG = (WORDS + GRP_WORDS - 1) / GRP_WORDS;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;
   localparam int SW = $clog2(GRP_WORDS);

   logic [NG*GRP_WORDS-1:0] cand_in;
   logic [NG*GRP_WORDS-1:0] cand_ff;
   logic [NG-1:0]           grp_in;
   logic [NG-1:0]           grp_ff;
   logic [GW-1:0]           sel;
   logic [GRP_WORDS-1:0]    sub;
   logic [SW-1:0]           idx;

   // stage one: words strictly after the base, folded into group bits
   always_comb begin
      cand_in = '0;
      for (int w = 0; w < WORDS; w++) begin
         cand_in[w] = flags[w] && (32'(w) > 32'(base));
      end
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = |cand_in[g*GRP_WORDS +: GRP_WORDS];
      end
   end

   always_ff @(posedge clock) begin
      if (strobe) begin
         cand_ff <= cand_in;
         grp_ff  <= grp_in;
      end
   end

   // stage two: lowest group, then lowest word inside it
   always_comb begin
      sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_ff[g]) begin
            sel = GW'(g);
         end
      end
      sub = cand_ff[32'(sel)*GRP_WORDS +: GRP_WORDS];
      idx = '0;
      for (int i = GRP_WORDS - 1; i >= 0; i--) begin
         if (sub[i]) begin
            idx = SW'(i);
         end
      end
   end

   assign found = |grp_ff;
   assign word  = IW'(32'(sel) * GRP_WORDS + 32'(idx));

endmodule

`default_nettype wire

FILE: rtl/core/bitmap_zero_bit_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_zero_bit_search_unit
// zero-bit search and zero-run count over an msb-first allocation bitmap
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one command per item (write word, find first zero, find
//   next zero, count zeros); rsp_* returns one answer item per command.
//   csr_* writes size_bits, the number of bitmap bits searched; write it
//   only while no command is in flight.
// sequence (accept to result register):
//   a write word goes straight to the result register; a search reads
//   the start word through the word memory's registered read port and,
//   if it holds no hit, reads the word found by the summary-flag encoder
//   before the answer is registered
//   one item in flight; the next is taken once the previous answer sits in
//   the output register, even if stalled
// reset:
//   every bitmap bit reads free (per-word empty flags), size_bits = 8192
// stall:
//   when rsp_tready is low the answer waits in the output register and the
//   unit holds its finished item until that register frees up
// ----------------------------------------------------------------------------
module bitmap_zero_bit_search_unit
   import bzs_pkg::*;
#(
   parameter int BITMAP_WORDS = DEFAULT_WORDS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command item
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // word_index[7:0], word_data[39:8], start_bit[53:40], max_count[67:54]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]             req_tuser,
   // answer item
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // answer[13:0]
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // size register write, size_bits[13:0]
   input  wire logic                   csr_tvalid,
   output logic                        csr_tready,
   input  wire logic [CSR_TDATA_W-1:0] csr_tdata
);

   localparam int IW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int CAP   = BITMAP_WORDS * WORD_BITS;
   localparam int POS_W = IW + 5;
   localparam int CMP_W = (POS_W > ANS_W) ? POS_W : ANS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WORD,
      S_PICK,
      S_WORD2,
      S_DONE
   } state_type;

   // request fields
   cmd_type              req_cmd;
   logic [IDX_W-1:0]     req_index;
   logic [WORD_BITS-1:0] req_data;
   logic [ANS_W-1:0]     req_start;
   logic [ANS_W-1:0]     req_max;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_index = req_tdata[7:0];
   assign req_data  = req_tdata[39:8];
   assign req_start = req_tdata[53:40];
   assign req_max   = req_tdata[67:54];

   // registers
   state_type          state_ff,    state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANS_W-1:0]   rsp_ans_ff,  rsp_ans_in;
   logic [ANS_W-1:0]   size_ff,     size_in;
   cmd_type            cmd_ff,      cmd_in;
   logic [ANS_W-1:0]   start_ff,    start_in;
   logic [ANS_W-1:0]   lim_ff,      lim_in;
   logic [ANS_W-1:0]   use_ff,      use_in;
   logic               early_ff,    early_in;
   logic               hit_ff,      hit_in;
   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic [IW-1:0]      loc_word_ff, loc_word_in;

   // datapath
   logic                 accept;
   logic [ANS_W-1:0]     start_eff;
   logic [ANS_W-1:0]     size_use;
   logic [ANS_W-1:0]     span;
   logic                 wr_en;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [BITMAP_WORDS-1:0] nonfull;
   logic [BITMAP_WORDS-1:0] nonempty;
   logic [BITMAP_WORDS-1:0] loc_flags;
   logic [IW-1:0]        base_word;
   logic                 loc_found;
   logic [IW-1:0]        loc_word;
   logic                 invert;
   logic [WORD_BITS-1:0] word_view;
   logic [WORD_BITS-1:0] enc_src;
   hit_type              enc;
   logic [IW-1:0]        word_sel;
   logic [CMP_W-1:0]     pos_wide;
   logic [CMP_W-1:0]     run_wide;
   logic [ANS_W-1:0]     answer;
   logic                 rsp_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ans_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // size in use is clipped to the bitmap capacity
   assign size_use  = (32'(size_ff) > CAP) ? ANS_W'(CAP) : size_ff;
   assign start_eff = (req_cmd == CMD_FIND_FIRST) ? '0 : req_start;
   assign span      = size_use - start_eff;

   // writes beyond the bitmap are dropped
   assign wr_en = accept && (req_cmd == CMD_WRITE) && (32'(req_index) < BITMAP_WORDS);

   // zero search hunts set bits of the inverted word, count hunts set bits
   assign invert    = (cmd_ff != CMD_COUNT);
   assign loc_flags = invert ? nonfull : nonempty;
   assign base_word = IW'(start_ff >> 5);

   bzs_store #(
      .WORDS (BITMAP_WORDS),
      .IW    (IW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (IW'(req_index)),
      .wr_data  (req_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .nonfull  (nonfull),
      .nonempty (nonempty)
   );

   bzs_locate #(
      .WORDS (BITMAP_WORDS),
      .IW    (IW)
   ) u_locate (
      .clock  (clock),
      .strobe (state_ff == S_WORD),
      .flags  (loc_flags),
      .base   (base_word),
      .found  (loc_found),
      .word   (loc_word)
   );

   // memory read: start word on accept, located word after the pick
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = IW'(start_eff >> 5);
      if (state_ff == S_IDLE) begin
         rd_en = accept && (req_cmd != CMD_WRITE);
      end else if (state_ff == S_PICK) begin
         rd_en   = !hit_ff && loc_found;
         rd_addr = loc_word;
      end
   end

   // in-word encoder, masked below the start offset on the first word
   always_comb begin
      word_view = rd_data ^ {WORD_BITS{invert}};
      if (state_ff == S_WORD) begin
         enc_src  = word_view & ({WORD_BITS{1'b1}} >> start_ff[4:0]);
         word_sel = base_word;
      end else begin
         enc_src  = word_view;
         word_sel = loc_word_ff;
      end
      enc = first_one_msb(enc_src);
   end

   // answer from the found position
   always_comb begin
      pos_wide = CMP_W'(pos_ff);
      run_wide = pos_wide - CMP_W'(start_ff);
      unique case (cmd_ff)
         CMD_WRITE: begin
            answer = '0;
         end
         CMD_COUNT: begin
            if (early_ff) begin
               answer = '0;
            end else if (hit_ff && (run_wide < CMP_W'(lim_ff))) begin
               answer = ANS_W'(run_wide);
            end else begin
               answer = lim_ff;
            end
         end
         default: begin
            if (!early_ff && hit_ff && (pos_wide < CMP_W'(use_ff))) begin
               answer = ANS_W'(pos_wide);
            end else begin
               answer = use_ff;
            end
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ans_in   = rsp_ans_ff;
      size_in      = (csr_tvalid && csr_tready) ? csr_tdata[ANS_W-1:0] : size_ff;
      cmd_in       = cmd_ff;
      start_in     = start_ff;
      lim_in       = lim_ff;
      use_in       = use_ff;
      early_in     = early_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      loc_word_in  = loc_word_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               start_in = start_eff;
               use_in   = size_use;
               early_in = (start_eff >= size_use);
               lim_in   = (req_max < span) ? req_max : span;
               hit_in   = 1'b0;
               state_in = (req_cmd == CMD_WRITE) ? S_DONE : S_WORD;
            end
         end
         S_WORD: begin
            hit_in   = enc.found;
            pos_in   = {word_sel, enc.offset};
            state_in = S_PICK;
         end
         S_PICK: begin
            loc_word_in = loc_word;
            if (!hit_ff && loc_found) begin
               state_in = S_WORD2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WORD2: begin
            hit_in   = enc.found;
            pos_in   = {word_sel, enc.offset};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = answer;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= RESET_SIZE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
      rsp_ans_ff  <= rsp_ans_in;
      cmd_ff      <= cmd_in;
      start_ff    <= start_in;
      lim_ff      <= lim_in;
      use_ff      <= use_in;
      early_ff    <= early_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      loc_word_ff <= loc_word_in;
   end

endmodule

`default_nettype wire

FILE: tb/sv/bitmap_zero_bit_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_zero_bit_search_unit_tb
// self-checking bench for the msb-first bitmap zero-bit search unit
// ----------------------------------------------------------------------------
// a table of directed commands at the reset size covers the empty map, the
// run limits and starts at and past the size. then phases at several sizes
// (zero, tiny, word edges, full and above capacity) send random commands
// that fill the bitmap front to back, so searches and counts reach deep.
// answers are predicted by a bit-level copy of the bitmap kept here and are
// compared in order. both sides idle at random, and the receiver holds off
// once for a long stretch so that the unit backs up its input.
// ----------------------------------------------------------------------------
module bitmap_zero_bit_search_unit_tb;
   import bzs_pkg::*;

   localparam int MAP_WORDS    = DEFAULT_WORDS;
   localparam int MAP_BITS     = MAP_WORDS * WORD_BITS;
   localparam int ITEM_TARGET  = 1650;
   localparam int PHASE_COUNT  = 9;
   localparam int HOLD_AFTER   = 400;   // items taken before the long hold-off
   localparam int HOLD_CYCLES  = 250;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] word_index;
      logic [31:0]      word_data;
      logic [ANS_W-1:0] start_bit;
      logic [ANS_W-1:0] max_count;
   } request_type;

   typedef struct packed {
      request_type      req;
      logic             typed;    // answer below is known without prediction
      logic [ANS_W-1:0] answer;
   } directed_row_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [ANS_W-1:0] answer;
   } answer_type;

   localparam logic [ANS_W-1:0] ALL_START = 14'h3FFF;
   localparam int DIRECTED_COUNT = 24;

   // command, word, data, start, max, typed, answer
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{CMD_FIND_FIRST, 8'd0,   32'h0000_0000, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd0,     ALL_START}, 1'b1, 14'd8192},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd8191,  14'd0},     1'b1, 14'd8191},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd8192,  14'd0},     1'b1, 14'd8192},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, ALL_START, 14'd0},     1'b1, 14'd8192},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, ALL_START, ALL_START}, 1'b1, 14'd0},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd8192,  14'd5},     1'b1, 14'd0},
      '{'{CMD_WRITE,      8'd0,   32'hFFFF_FFFF, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_FIND_FIRST, 8'd0,   32'h0000_0000, 14'd0,     14'd0},     1'b1, 14'd32},
      '{'{CMD_WRITE,      8'd1,   32'h8000_0000, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_FIND_FIRST, 8'd0,   32'h0000_0000, 14'd0,     14'd0},     1'b1, 14'd33},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd33,    ALL_START}, 1'b1, 14'd8159},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd31,    14'd10},    1'b1, 14'd0},
      '{'{CMD_WRITE,      8'd255, 32'h0000_0001, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd8160,  14'd0},     1'b1, 14'd8160},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd8160,  ALL_START}, 1'b1, 14'd31},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd8191,  14'd0},     1'b1, 14'd8192},
      '{'{CMD_WRITE,      8'd2,   32'h5555_AAAA, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_WRITE,      8'd3,   32'hFFFF_0000, 14'd0,     14'd0},     1'b1, 14'd0},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd64,    14'd100},   1'b0, 14'd0},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd65,    14'd0},     1'b0, 14'd0},
      '{'{CMD_COUNT,      8'd0,   32'h0000_0000, 14'd112,   ALL_START}, 1'b0, 14'd0},
      '{'{CMD_FIND_NEXT,  8'd0,   32'h0000_0000, 14'd96,    14'd0},     1'b0, 14'd0}
   };

   // dut ports
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // word_index, word_data, start_bit, max_count
   logic [1:0]             req_tuser;   // command
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // answer
   logic                   csr_tvalid;
   logic                   csr_tready;
   logic [CSR_TDATA_W-1:0] csr_tdata;   // size_bits

   // bench-side copy of the unit state
   logic [WORD_BITS-1:0] alloc_map [MAP_WORDS];
   logic [ANS_W-1:0]     search_size;
   int unsigned          fill_word;

   answer_type   pending_answers[$];
   int unsigned  items_taken;
   int unsigned  answers_seen;
   int unsigned  fail_count;

   bitmap_zero_bit_search_unit #(
      .BITMAP_WORDS(MAP_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // answer prediction
   // ------------------------------------------------------------------------

   // sizes above the bitmap capacity search the whole bitmap
   function automatic int unsigned used_size();
      return (int'(search_size) > MAP_BITS) ? MAP_BITS : int'(search_size);
   endfunction

   function automatic logic map_bit(int unsigned b);
      return alloc_map[b / WORD_BITS][WORD_BITS - 1 - (b % WORD_BITS)];
   endfunction

   // lowest free bit at or after from, or limit when all below limit are taken
   function automatic int unsigned first_free_from(int unsigned from, int unsigned limit);
      int unsigned b;
      b = from;
      while (b < limit) begin
         // a full word is skipped whole, overshooting the limit still means none
         if ((b % WORD_BITS) == 0 && alloc_map[b / WORD_BITS] == '1) begin
            b += WORD_BITS;
         end else if (!map_bit(b)) begin
            return b;
         end else begin
            b++;
         end
      end
      return limit;
   endfunction

   // length of the free run starting at from, clipped to max and to the limit
   function automatic int unsigned free_run_length(int unsigned from, int unsigned limit,
                                                   int unsigned max);
      int unsigned b;
      int unsigned span;
      int unsigned run;
      if (from >= limit) begin
         return 0;
      end
      span = (max > limit - from) ? limit - from : max;
      b    = from;
      run  = 0;
      while (run < span) begin
         if ((b % WORD_BITS) == 0 && span - run >= WORD_BITS
             && alloc_map[b / WORD_BITS] == '0) begin
            b   += WORD_BITS;
            run += WORD_BITS;
         end else if (map_bit(b)) begin
            break;
         end else begin
            b++;
            run++;
         end
      end
      return run;
   endfunction

   // applies one command to the bitmap copy and returns its answer
   function automatic logic [ANS_W-1:0] predict_answer(request_type r);
      int unsigned lim;
      int unsigned ans;
      lim = used_size();
      ans = 0;
      case (r.cmd)
         CMD_WRITE: begin
            if (int'(r.word_index) < MAP_WORDS) begin
               alloc_map[r.word_index] = r.word_data;
            end
         end
         CMD_FIND_FIRST: ans = first_free_from(0, lim);
         CMD_FIND_NEXT: begin
            ans = (int'(r.start_bit) >= lim) ? lim : first_free_from(r.start_bit, lim);
         end
         default: ans = free_run_length(r.start_bit, lim, r.max_count);
      endcase
      return ANS_W'(ans);
   endfunction

   // ------------------------------------------------------------------------
   // random commands: mostly fills of the bitmap from the front, with holes
   // and zero words mixed in, and searches that mostly start within or at the size
   // ------------------------------------------------------------------------
   function automatic request_type random_request();
      request_type r;
      int unsigned lim;
      int unsigned top_word;
      int unsigned roll;
      lim      = used_size();
      top_word = lim / WORD_BITS;
      if (top_word > MAP_WORDS - 1) begin
         top_word = MAP_WORDS - 1;
      end
      r.word_index = IDX_W'($urandom);
      r.word_data  = $urandom;
      r.start_bit  = ANS_W'($urandom);
      r.max_count  = ANS_W'($urandom);

      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         r.cmd = CMD_WRITE;
      end else if (roll < 50) begin
         r.cmd = CMD_FIND_FIRST;
      end else if (roll < 75) begin
         r.cmd = CMD_FIND_NEXT;
      end else begin
         r.cmd = CMD_COUNT;
      end

      if (r.cmd == CMD_WRITE) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            // walk the fill pointer through the words in use
            r.word_index = IDX_W'(fill_word);
            fill_word    = (fill_word >= top_word) ? 0 : fill_word + 1;
         end else if (roll < 80) begin
            r.word_index = IDX_W'($urandom_range(0, top_word));
         end
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            r.word_data = '1;
         end else if (roll < 55) begin
            r.word_data = ~(32'h1 << $urandom_range(0, 31));   // single hole
         end else if (roll < 65) begin
            r.word_data = '0;
         end else if (roll < 75) begin
            r.word_data = 32'hFFFF_FFFF << $urandom_range(1, 31);  // run into next word
         end
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            r.start_bit = ANS_W'($urandom_range(0, lim));
         end else if (roll < 85) begin
            r.start_bit = ANS_W'($urandom_range(0, top_word) * WORD_BITS);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            r.max_count = ANS_W'($urandom_range(0, 40));
         end else if (roll < 65) begin
            r.max_count = ANS_W'($urandom_range(0, lim + 40));
         end else if (roll < 80) begin
            r.max_count = '1;
         end else if (roll < 85) begin
            r.max_count = '0;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // command side
   // ------------------------------------------------------------------------
   int unsigned burst_left;

   // offers one item and books its answer once it is taken
   task automatic send_item(input request_type r, input logic typed,
                            input logic [ANS_W-1:0] typed_answer);
      answer_type a;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {4'b0000, r.max_count, r.start_bit, r.word_data, r.word_index};
      do @(posedge clock); while (!req_tready);
      a.cmd    = r.cmd;
      a.answer = predict_answer(r);
      if (typed) begin
         a.answer = typed_answer;
      end
      pending_answers.push_back(a);
      items_taken++;
   endtask

   // drops valid with junk on the data lines; n sets how long valid stays low
   task automatic idle_cycles(input int unsigned n);
      logic [95:0] junk;
      junk = {$urandom, $urandom, $urandom};
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= junk[REQ_TDATA_W-1:0];
      req_tuser  <= junk[95:94];
      repeat (n - 1) @(negedge clock);
   endtask

   // bursts of random length, some long enough to run without any gap
   task automatic pace_sender();
      burst_left--;
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 10));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 15);
      end
   endtask

   // stop offering and let every booked answer come back
   task automatic drain_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_size(input logic [ANS_W-1:0] value);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {2'b00, value};
      do @(posedge clock); while (!csr_tready);
      search_size = value;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [ANS_W-1:0] phase_sizes [PHASE_COUNT];
      int unsigned      per_phase;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_WRITE;
      csr_tvalid  = 1'b0;
      csr_tdata   = '0;
      search_size = RESET_SIZE;
      fill_word   = 0;
      items_taken = 0;
      burst_left  = $urandom_range(1, 20);
      for (int i = 0; i < MAP_WORDS; i++) begin
         alloc_map[i] = '0;
      end

      // above capacity, empty, tiny, word edges, a random size and full
      phase_sizes = '{14'h3FFF, 14'd0, 14'd1, 14'd33, 14'd8191,
                      ANS_W'($urandom_range(2, 8190)), 14'd32, 14'd31, 14'd8192};
      per_phase = (ITEM_TARGET - DIRECTED_COUNT) / PHASE_COUNT;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset size on an empty bitmap
      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].answer);
         pace_sender();
      end

      // random phases, each at its own size, size changed only when drained
      foreach (phase_sizes[p]) begin
         drain_answers();
         write_size(phase_sizes[p]);
         repeat (per_phase) begin
            send_item(random_request(), 1'b0, '0);
            pace_sender();
         end
      end

      drain_answers();
      // wait for any stray answer to show up
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // answer side: stall pattern, with one long hold-off while commands are
   // still being offered so the unit fills and stalls req_tready
   // ------------------------------------------------------------------------
   initial begin : answer_stalls
      int unsigned mode;
      int unsigned mode_left;
      logic        held_off;
      rsp_tready = 1'b0;
      mode       = 0;
      mode_left  = 0;
      held_off   = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && items_taken >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            held_off    = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;                             // no stalls
               1:       rsp_tready <= ($urandom_range(0, 1) == 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);      // mostly stalled
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // answers are checked in order against the oldest booked one
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("answer %0d: unexpected item, answer %0d", answers_seen,
                        rsp_tdata[ANS_W-1:0]);
            end
         end else begin
            a = pending_answers.pop_front();
            if (rsp_tdata[ANS_W-1:0] !== a.answer) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("answer %0d (%s): expected %0d, got %0d", answers_seen,
                           a.cmd.name(), a.answer, rsp_tdata[ANS_W-1:0]);
               end
            end
         end
      end
   end

   initial begin : run_limit
      answers_seen = 0;
      fail_count   = 0;
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
